// ===== hw/rtl/rlt_pkg.sv =====
// Shared types and codes for the region lifecycle table.
// Request codes, region state encoding and the per-word status flags.
// No dependencies.
package rlt_pkg;

    // Transition request codes
    typedef enum logic [3:0] {
        F_ALLOC     = 4'd0,
        F_BYPASS    = 4'd1,
        F_HUMSTART  = 4'd2,
        F_HUMCONT   = 4'd3,
        F_PIN       = 4'd4,
        F_UNPIN     = 4'd5,
        F_CSET      = 4'd6,
        F_TRASH     = 4'd7,
        F_EMPTYCOMM = 4'd8,
        F_UNCOMMIT  = 4'd9
    } func_t;

    // Region lifecycle states; empty uncommitted is all zeros (reset value)
    typedef enum logic [2:0] {
        ST_EU    = 3'd0,
        ST_EC    = 3'd1,
        ST_REG   = 3'd2,
        ST_HS    = 3'd3,
        ST_HC    = 3'd4,
        ST_CSET  = 3'd5,
        ST_TRASH = 3'd6,
        ST_PIN   = 3'd7
    } region_state_t;

    localparam int STATE_W = 3;
    localparam int PINS_OUT_W = 16;

    // Status flags reported with each result word
    typedef struct packed {
        logic granted;
        logic commit;
        logic uncommit;
        logic stamp;
        logic illegal;
    } rlt_flags_t;

endpackage

// ===== hw/rtl/rlt_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the region entry table. No dependencies.
module rlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port; data holds while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/rlt_rules.sv =====
// Transition rules of the region lifecycle table: next state, next pin count, flags.
// Pure combinational. Depends on rlt_pkg.
module rlt_rules #(
    parameter int PIN_WIDTH = 16
) (
    input  logic [3:0]              func,
    input  rlt_pkg::region_state_t  cur_state,
    input  logic [PIN_WIDTH-1:0]    cur_pins,
    output rlt_pkg::region_state_t  nxt_state,
    output logic [PIN_WIDTH-1:0]    nxt_pins,
    output rlt_pkg::rlt_flags_t     flags
);

    logic ok;
    logic grant;
    logic commit;
    logic uncommit;
    logic stamp;
    rlt_pkg::region_state_t ns;
    logic [PIN_WIDTH-1:0] np;

    // apply the request to the current entry
    always_comb
    begin
        ok       = 1'b1;
        grant    = 1'b1;
        commit   = 1'b0;
        uncommit = 1'b0;
        stamp    = 1'b0;
        ns       = cur_state;
        np       = cur_pins;
        case (func)
            rlt_pkg::F_ALLOC:
            begin
                if (cur_state == rlt_pkg::ST_EU || cur_state == rlt_pkg::ST_EC)
                begin
                    commit = (cur_state == rlt_pkg::ST_EU);
                    ns     = rlt_pkg::ST_REG;
                end
                else if (cur_state == rlt_pkg::ST_REG || cur_state == rlt_pkg::ST_PIN)
                begin
                    grant = 1'b0;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            rlt_pkg::F_BYPASS:
            begin
                if (cur_state == rlt_pkg::ST_EU || cur_state == rlt_pkg::ST_EC ||
                    cur_state == rlt_pkg::ST_CSET)
                begin
                    commit = (cur_state == rlt_pkg::ST_EU);
                    ns     = rlt_pkg::ST_REG;
                end
                else if (cur_state != rlt_pkg::ST_REG && cur_state != rlt_pkg::ST_PIN)
                begin
                    ok = 1'b0;
                end
            end
            rlt_pkg::F_HUMSTART, rlt_pkg::F_HUMCONT:
            begin
                if (cur_state == rlt_pkg::ST_EU || cur_state == rlt_pkg::ST_EC)
                begin
                    commit = (cur_state == rlt_pkg::ST_EU);
                    ns     = (func == rlt_pkg::F_HUMSTART) ? rlt_pkg::ST_HS : rlt_pkg::ST_HC;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            rlt_pkg::F_PIN:
            begin
                if (cur_state == rlt_pkg::ST_REG || cur_state == rlt_pkg::ST_PIN)
                begin
                    // refuse a pin that would wrap the count
                    if (&cur_pins)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        ns = rlt_pkg::ST_PIN;
                        np = cur_pins + PIN_WIDTH'(1);
                    end
                end
                else if (cur_state != rlt_pkg::ST_HS && cur_state != rlt_pkg::ST_HC)
                begin
                    ok = 1'b0;
                end
            end
            rlt_pkg::F_UNPIN:
            begin
                if (cur_state == rlt_pkg::ST_PIN)
                begin
                    // a pinned entry with zero count just drops back to regular
                    if (cur_pins != '0)
                    begin
                        np = cur_pins - PIN_WIDTH'(1);
                    end
                    if (cur_pins <= PIN_WIDTH'(1))
                    begin
                        ns = rlt_pkg::ST_REG;
                    end
                end
                else if (cur_state != rlt_pkg::ST_REG && cur_state != rlt_pkg::ST_HS &&
                         cur_state != rlt_pkg::ST_HC)
                begin
                    ok = 1'b0;
                end
            end
            rlt_pkg::F_CSET:
            begin
                if (cur_state == rlt_pkg::ST_REG)
                begin
                    ns = rlt_pkg::ST_CSET;
                end
                else if (cur_state != rlt_pkg::ST_CSET)
                begin
                    ok = 1'b0;
                end
            end
            rlt_pkg::F_TRASH:
            begin
                if (cur_state == rlt_pkg::ST_CSET || cur_state == rlt_pkg::ST_HS ||
                    cur_state == rlt_pkg::ST_HC || cur_state == rlt_pkg::ST_REG)
                begin
                    ns = rlt_pkg::ST_TRASH;
                end
                else if (cur_state != rlt_pkg::ST_TRASH)
                begin
                    ok = 1'b0;
                end
            end
            rlt_pkg::F_EMPTYCOMM:
            begin
                if (cur_state == rlt_pkg::ST_TRASH)
                begin
                    ns    = rlt_pkg::ST_EC;
                    stamp = 1'b1;
                end
                else if (cur_state != rlt_pkg::ST_EC)
                begin
                    ok = 1'b0;
                end
            end
            rlt_pkg::F_UNCOMMIT:
            begin
                if (cur_state == rlt_pkg::ST_EC)
                begin
                    ns       = rlt_pkg::ST_EU;
                    uncommit = 1'b1;
                end
                else if (cur_state == rlt_pkg::ST_EU)
                begin
                    grant = 1'b0;
                end
                else
                begin
                    ok = 1'b0;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase

        // refused request: entry unchanged, all outcome flags cleared
        if (!ok)
        begin
            ns       = cur_state;
            np       = cur_pins;
            grant    = 1'b0;
            commit   = 1'b0;
            uncommit = 1'b0;
            stamp    = 1'b0;
        end
    end

    assign nxt_state      = ns;
    assign nxt_pins       = np;
    assign flags.granted  = grant;
    assign flags.commit   = commit;
    assign flags.uncommit = uncommit;
    assign flags.stamp    = stamp;
    assign flags.illegal  = !ok;

endmodule

// ===== hw/rtl/region_lifecycle_table.sv =====
// Region lifecycle table top level: entry memory, read-modify-write pipeline, output word.
// Depends on rlt_pkg, rlt_ram and rlt_rules.
//
// Each input word names a region and a transition request; the block returns one
// result word with the region's state and pin count after the request plus the
// grant, commit, uncommit, empty-stamp and illegal flags. Throughput is one word per
// cycle while the output side takes results: the entry is read from the table memory
// (one read port, one write port) in the accept cycle, the rule is applied, and once
// the output side can take the result the new entry is written back as the result is
// registered into the output word. Back-to-back requests to the same region are served
// by forwarding the last written entry. After reset the table is cleared one entry per
// cycle, all REGIONS entries, with in_stall held high. A region index at or above
// REGIONS is refused as illegal with zero state and pin count, and no entry is touched.
module region_lifecycle_table #(
    parameter int REGIONS   = 1024,
    parameter int PIN_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  func,
    input  logic [9:0]  region,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  state_after,
    output logic [15:0] pins_after,
    output logic        granted,
    output logic        commit_request,
    output logic        uncommit_request,
    output logic        empty_stamp,
    output logic        illegal
);

    localparam int AW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int EW = rlt_pkg::STATE_W + PIN_WIDTH;
    localparam logic [AW-1:0] LAST_ADDR = AW'(REGIONS - 1);

    // clearing pass
    logic          clear_reg;
    logic          clear_next;
    logic [AW-1:0] clear_cnt_reg;
    logic [AW-1:0] clear_cnt_next;

    // pipeline stage holding the word whose entry is being read
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic [3:0]    s1_func_reg;
    logic [AW-1:0] s1_addr_reg;
    logic          s1_inr_reg;

    // last written entry, for forwarding
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [EW-1:0] fwd_data_reg;

    // output word
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [2:0]    state_after_reg;
    logic [15:0]   pins_after_reg;
    rlt_pkg::rlt_flags_t flags_reg;

    logic          accept;
    logic          s1_adv;
    logic          s1_wr;
    logic [16:0]   region_ext;
    logic [AW-1:0] in_addr;
    logic          in_range;
    logic [EW-1:0] rd_data;
    logic [EW-1:0] cur_entry;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    rlt_pkg::region_state_t cur_state;
    logic [PIN_WIDTH-1:0]   cur_pins;
    rlt_pkg::region_state_t nxt_state;
    logic [PIN_WIDTH-1:0]   nxt_pins;
    logic [31:0]            nxt_pins_ext;
    rlt_pkg::rlt_flags_t    nxt_flags;

    // handshake and address decode
    assign region_ext = 17'(region);
    assign in_addr    = region_ext[AW-1:0];
    assign in_range   = (region_ext < 17'(REGIONS));
    assign accept     = in_valid && !in_stall;
    assign s1_adv     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall   = clear_reg || (s1_valid_reg && !s1_adv);

    // entry with forwarding of the latest write
    assign cur_entry = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : rd_data;
    assign cur_state = rlt_pkg::region_state_t'(cur_entry[rlt_pkg::STATE_W-1:0]);
    assign cur_pins  = cur_entry[EW-1:rlt_pkg::STATE_W];

    rlt_rules #(
        .PIN_WIDTH(PIN_WIDTH)
    ) u_rules (
        .func      (s1_func_reg),
        .cur_state (cur_state),
        .cur_pins  (cur_pins),
        .nxt_state (nxt_state),
        .nxt_pins  (nxt_pins),
        .flags     (nxt_flags)
    );

    assign nxt_pins_ext = 32'(nxt_pins);

    // write back: clearing pass first, then legal in-range updates
    assign s1_wr     = s1_adv && s1_inr_reg && !nxt_flags.illegal;
    assign ram_we    = clear_reg || s1_wr;
    assign ram_waddr = clear_reg ? clear_cnt_reg : s1_addr_reg;
    assign ram_wdata = clear_reg ? '0 : {nxt_pins, nxt_state};

    rlt_ram #(
        .WIDTH (EW),
        .DEPTH (REGIONS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (rd_data)
    );

    // next-state logic for control registers
    always_comb
    begin
        clear_next     = clear_reg && (clear_cnt_reg != LAST_ADDR);
        clear_cnt_next = clear_reg ? clear_cnt_reg + AW'(1) : clear_cnt_reg;
        s1_valid_next  = accept || (s1_valid_reg && !s1_adv);
        out_valid_next = s1_adv || (out_valid_reg && out_stall);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg     <= 1'b1;
            clear_cnt_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            clear_reg     <= clear_next;
            clear_cnt_reg <= clear_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_wr)
            begin
                fwd_valid_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg <= func;
            s1_addr_reg <= in_addr;
            s1_inr_reg  <= in_range;
        end
        if (s1_wr)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= {nxt_pins, nxt_state};
        end
        if (s1_adv)
        begin
            if (s1_inr_reg)
            begin
                state_after_reg <= nxt_state;
                pins_after_reg  <= nxt_pins_ext[15:0];
                flags_reg       <= nxt_flags;
            end
            else
            begin
                state_after_reg <= '0;
                pins_after_reg  <= '0;
                flags_reg       <= '{granted: 1'b0, commit: 1'b0, uncommit: 1'b0,
                                     stamp: 1'b0, illegal: 1'b1};
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign state_after      = state_after_reg;
    assign pins_after       = pins_after_reg;
    assign granted          = flags_reg.granted;
    assign commit_request   = flags_reg.commit;
    assign uncommit_request = flags_reg.uncommit;
    assign empty_stamp      = flags_reg.stamp;
    assign illegal          = flags_reg.illegal;

    // no word may be in flight while the table is being cleared
    a_no_work_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_reg |-> !s1_valid_reg && !out_valid_reg)
        else $error("word in flight during clearing pass");

    // a refused word reports no outcome
    a_illegal_no_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && illegal |-> !granted && !commit_request &&
            !uncommit_request && !empty_stamp)
        else $error("illegal word carries an outcome flag");

    // a commit only leaves empty uncommitted for an allocated state
    a_commit_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && commit_request |-> state_after == rlt_pkg::ST_REG ||
            state_after == rlt_pkg::ST_HS || state_after == rlt_pkg::ST_HC)
        else $error("commit with unexpected resulting state");

    // an uncommit always lands in empty uncommitted
    a_uncommit_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && uncommit_request |-> state_after == rlt_pkg::ST_EU)
        else $error("uncommit with unexpected resulting state");

    // an empty stamp always lands in empty committed
    a_stamp_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && empty_stamp |-> state_after == rlt_pkg::ST_EC)
        else $error("empty stamp with unexpected resulting state");

endmodule

// ===== tb/rlt_lifecycle_checker.sv =====
// Checker for the region lifecycle table: watches both channels, predicts each result word
// from its own copy of the region table, and compares field by field.
// Depends on rlt_pkg.
module rlt_lifecycle_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [3:0]  func,
    input  logic [9:0]  region,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  state_after,
    input  logic [15:0] pins_after,
    input  logic        granted,
    input  logic        commit_request,
    input  logic        uncommit_request,
    input  logic        empty_stamp,
    input  logic        illegal,
    output int          mismatches,
    output int          outstanding
);
    import rlt_pkg::*;

    localparam int          REGION_COUNT = 1024;
    localparam logic [15:0] PIN_CEILING  = 16'hFFFF;

    typedef struct packed {
        region_state_t st;
        logic [15:0]   pins;
        rlt_flags_t    flags;
    } lifecycle_word_t;

    // Shadow of the region table
    region_state_t   shadow_state [REGION_COUNT];
    logic [15:0]     shadow_pins  [REGION_COUNT];
    lifecycle_word_t pending_words [$];

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Apply one request to the shadow table and return the word it should produce
    function automatic lifecycle_word_t apply_request(input logic [3:0] code,
                                                      input logic [9:0] idx);
        lifecycle_word_t res;
        region_state_t   cur;
        region_state_t   nxt;
        logic [15:0]     cnt;
        logic [15:0]     ncnt;
        logic            ok;
        logic            grant;
        logic            commit;
        logic            release_mem;
        logic            stamp;
        res = '0;
        if (int'(idx) >= REGION_COUNT)
        begin
            res.flags.illegal = 1'b1;
            return res;
        end
        cur = shadow_state[idx];
        cnt = shadow_pins[idx];
        nxt = cur;
        ncnt = cnt;
        ok = 1'b1;
        grant = 1'b1;
        commit = 1'b0;
        release_mem = 1'b0;
        stamp = 1'b0;
        case (code)
            F_ALLOC:
                if (cur == ST_EU || cur == ST_EC)
                begin
                    commit = (cur == ST_EU);
                    nxt = ST_REG;
                end
                else if (cur == ST_REG || cur == ST_PIN) grant = 1'b0;
                else ok = 1'b0;
            F_BYPASS:
                if (cur == ST_EU || cur == ST_EC || cur == ST_CSET)
                begin
                    commit = (cur == ST_EU);
                    nxt = ST_REG;
                end
                else if (cur != ST_REG && cur != ST_PIN) ok = 1'b0;
            F_HUMSTART, F_HUMCONT:
                if (cur == ST_EU || cur == ST_EC)
                begin
                    commit = (cur == ST_EU);
                    nxt = (code == F_HUMSTART) ? ST_HS : ST_HC;
                end
                else ok = 1'b0;
            F_PIN:
                if (cur == ST_REG || cur == ST_PIN)
                begin
                    // refuse a pin that would wrap the count
                    if (cnt == PIN_CEILING) ok = 1'b0;
                    else
                    begin
                        nxt = ST_PIN;
                        ncnt = cnt + 16'd1;
                    end
                end
                else if (cur != ST_HS && cur != ST_HC) ok = 1'b0;
            F_UNPIN:
                if (cur == ST_PIN)
                begin
                    if (cnt != 16'd0) ncnt = cnt - 16'd1;
                    if (ncnt == 16'd0) nxt = ST_REG;
                end
                else if (cur != ST_REG && cur != ST_HS && cur != ST_HC) ok = 1'b0;
            F_CSET:
                if (cur == ST_REG) nxt = ST_CSET;
                else if (cur != ST_CSET) ok = 1'b0;
            F_TRASH:
                if (cur == ST_CSET || cur == ST_HS || cur == ST_HC || cur == ST_REG)
                    nxt = ST_TRASH;
                else if (cur != ST_TRASH) ok = 1'b0;
            F_EMPTYCOMM:
                if (cur == ST_TRASH)
                begin
                    nxt = ST_EC;
                    stamp = 1'b1;
                end
                else if (cur != ST_EC) ok = 1'b0;
            F_UNCOMMIT:
                if (cur == ST_EC)
                begin
                    nxt = ST_EU;
                    release_mem = 1'b1;
                end
                else if (cur == ST_EU) grant = 1'b0;
                else ok = 1'b0;
            default:
                ok = 1'b0;
        endcase
        // refused requests leave the entry alone and clear every flag but illegal
        if (!ok)
        begin
            nxt = cur;
            ncnt = cnt;
            grant = 1'b0;
            commit = 1'b0;
            release_mem = 1'b0;
            stamp = 1'b0;
        end
        else
        begin
            shadow_state[idx] = nxt;
            shadow_pins[idx] = ncnt;
        end
        res.st = nxt;
        res.pins = ncnt;
        res.flags.granted = grant;
        res.flags.commit = commit;
        res.flags.uncommit = release_mem;
        res.flags.stamp = stamp;
        res.flags.illegal = !ok;
        return res;
    endfunction

    // Compare results first, then queue the prediction for a word accepted at the same edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        lifecycle_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < REGION_COUNT; i++)
            begin
                shadow_state[i] = ST_EU;
                shadow_pins[i] = 16'd0;
            end
            pending_words.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
            begin
                if (pending_words.size() == 0)
                    report("word with nothing expected", 16'(state_after), 16'd0);
                else
                begin
                    want = pending_words.pop_front();
                    if (state_after !== want.st)
                        report("state_after", 16'(state_after), 16'(want.st));
                    if (pins_after !== want.pins)
                        report("pins_after", pins_after, want.pins);
                    if (granted !== want.flags.granted)
                        report("granted", 16'(granted), 16'(want.flags.granted));
                    if (commit_request !== want.flags.commit)
                        report("commit_request", 16'(commit_request), 16'(want.flags.commit));
                    if (uncommit_request !== want.flags.uncommit)
                        report("uncommit_request", 16'(uncommit_request),
                               16'(want.flags.uncommit));
                    if (empty_stamp !== want.flags.stamp)
                        report("empty_stamp", 16'(empty_stamp), 16'(want.flags.stamp));
                    if (illegal !== want.flags.illegal)
                        report("illegal", 16'(illegal), 16'(want.flags.illegal));
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0)
                pending_words.push_back(apply_request(func, region));
            outstanding = pending_words.size();
        end
    end

endmodule

// ===== tb/tb_region_lifecycle_table.sv =====
// Testbench top for the region lifecycle table: clock, reset, request stimulus,
// result-side stalls and the verdict. Depends on rlt_pkg, region_lifecycle_table
// and rlt_lifecycle_checker.
module tb_region_lifecycle_table;
    import rlt_pkg::*;

    localparam int          RANDOM_WORDS  = 1400;
    localparam int          CYCLE_LIMIT   = 1000000;
    localparam int          SQUEEZE_AFTER = 300;
    localparam int          SQUEEZE_LEN   = 400;
    localparam int          PIN_RUN       = 8;
    localparam logic [3:0]  F_UNDEFINED   = 4'd15;
    localparam logic [9:0]  TOP_REGION    = 10'd1023;
    localparam logic [9:0]  NOISE_BASE    = 10'd512;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  func;
    logic [9:0]  region;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  state_after;
    logic [15:0] pins_after;
    logic        granted;
    logic        commit_request;
    logic        uncommit_request;
    logic        empty_stamp;
    logic        illegal;

    int mismatches;
    int outstanding;
    int words_sent;
    int phase_base;
    int cycles;
    bit no_idle;
    bit random_phase;
    bit squeeze_done;

    region_lifecycle_table u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .region           (region),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .state_after      (state_after),
        .pins_after       (pins_after),
        .granted          (granted),
        .commit_request   (commit_request),
        .uncommit_request (uncommit_request),
        .empty_stamp      (empty_stamp),
        .illegal          (illegal)
    );

    rlt_lifecycle_checker u_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .func             (func),
        .region           (region),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .state_after      (state_after),
        .pins_after       (pins_after),
        .granted          (granted),
        .commit_request   (commit_request),
        .uncommit_request (uncommit_request),
        .empty_stamp      (empty_stamp),
        .illegal          (illegal),
        .mismatches       (mismatches),
        .outstanding      (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle watchdog
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_region_lifecycle_table: done, errors");
        $finish;
    end

    // Offer one request word after a random gap (none while no_idle is set) and hold it until accepted
    task automatic send(input logic [3:0] code, input logic [9:0] idx);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        func <= code;
        region <= idx;
        do @(posedge clk); while (in_stall !== 1'b0);
        words_sent++;
        @(negedge clk);
    endtask

    // A full region life: take it into use, maybe pin it, retire it, maybe release memory.
    // Leaves a region that started empty empty again, committed or not.
    task automatic run_lifecycle(input logic [9:0] idx);
        int         kind;
        int         pins_n;
        int         unpins_n;
        logic [3:0] entry;
        kind = $urandom_range(0, 3);
        case (kind)
            0:       entry = F_ALLOC;
            1:       entry = F_BYPASS;
            2:       entry = F_HUMSTART;
            default: entry = F_HUMCONT;
        endcase
        if ($urandom_range(0, 3) == 0) send(F_UNCOMMIT, idx);
        send(entry, idx);
        if (kind < 2)
        begin
            if ($urandom_range(0, 2) == 0) send(F_ALLOC, idx);
            pins_n = $urandom_range(0, 4);
            unpins_n = $urandom_range(0, pins_n + 1);
            repeat (pins_n) send(F_PIN, idx);
            repeat (unpins_n) send(F_UNPIN, idx);
            if ($urandom_range(0, 2) == 0) send(F_BYPASS, idx);
            if (unpins_n < pins_n) repeat (pins_n - unpins_n) send(F_UNPIN, idx);
            send(F_CSET, idx);
            if ($urandom_range(0, 2) == 0) send(F_CSET, idx);
            if ($urandom_range(0, 2) == 0)
            begin
                send(F_BYPASS, idx);
                send(F_CSET, idx);
            end
        end
        else
        begin
            if ($urandom_range(0, 1) == 0) send(F_PIN, idx);
            if ($urandom_range(0, 1) == 0) send(F_UNPIN, idx);
        end
        send(F_TRASH, idx);
        if ($urandom_range(0, 2) == 0) send(F_TRASH, idx);
        send(F_EMPTYCOMM, idx);
        if ($urandom_range(0, 2) == 0) send(F_EMPTYCOMM, idx);
        if ($urandom_range(0, 2) != 0) send(F_UNCOMMIT, idx);
    endtask

    // Result side: random stall before each word, plus one long hold-off to back up the input
    initial
    begin : receiver
        int stall_len;
        out_stall = 1'b0;
        squeeze_done = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (!squeeze_done && random_phase && words_sent - phase_base >= SQUEEZE_AFTER)
            begin
                squeeze_done = 1'b1;
                out_stall <= 1'b1;
                repeat (SQUEEZE_LEN) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                stall_len = no_idle ? 0 : $urandom_range(0, 19);
                if (stall_len != 0)
                begin
                    out_stall <= 1'b1;
                    repeat (stall_len) @(negedge clk);
                    out_stall <= 1'b0;
                end
            end
            do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
            @(negedge clk);
        end
    end

    // Stimulus and verdict
    initial
    begin : stimulus
        int         pick;
        logic [9:0] noise_idx;
        rst_n = 1'b0;
        in_valid = 1'b0;
        func = F_ALLOC;
        region = 10'd0;
        words_sent = 0;
        phase_base = 0;
        no_idle = 1'b0;
        random_phase = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every request but the humongous continuation, refusals, grant-0 cases and fall-throughs on region 0
        send(F_UNCOMMIT, 10'd0);
        send(F_PIN, 10'd0);
        send(F_UNDEFINED, 10'd0);
        send(F_ALLOC, 10'd0);
        send(F_ALLOC, 10'd0);
        send(F_PIN, 10'd0);
        send(F_PIN, 10'd0);
        send(F_ALLOC, 10'd0);
        send(F_BYPASS, 10'd0);
        send(F_UNPIN, 10'd0);
        send(F_UNPIN, 10'd0);
        send(F_UNPIN, 10'd0);
        send(F_CSET, 10'd0);
        send(F_CSET, 10'd0);
        send(F_BYPASS, 10'd0);
        send(F_TRASH, 10'd0);
        send(F_TRASH, 10'd0);
        send(F_EMPTYCOMM, 10'd0);
        send(F_EMPTYCOMM, 10'd0);
        send(F_HUMSTART, 10'd0);
        send(F_PIN, 10'd0);
        send(F_TRASH, 10'd0);
        send(F_EMPTYCOMM, 10'd0);
        send(F_UNCOMMIT, 10'd0);
        // highest region: humongous continuation, then back to regular for the pin run
        send(F_HUMCONT, TOP_REGION);
        send(F_UNPIN, TOP_REGION);
        send(F_TRASH, TOP_REGION);
        send(F_EMPTYCOMM, TOP_REGION);
        send(F_ALLOC, TOP_REGION);

        // Back-to-back pins on one region at full rate, then a refused collection set
        no_idle = 1'b1;
        repeat (PIN_RUN) send(F_PIN, TOP_REGION);
        send(F_PIN, TOP_REGION);
        send(F_UNPIN, TOP_REGION);
        send(F_PIN, TOP_REGION);
        send(F_PIN, TOP_REGION);
        send(F_CSET, TOP_REGION);
        no_idle = 1'b0;

        // Random: mostly clean lifecycles, some on the noise pool, some raw noise
        phase_base = words_sent;
        random_phase = 1'b1;
        while (words_sent - phase_base < RANDOM_WORDS)
        begin
            no_idle = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                run_lifecycle(10'($urandom_range(0, 511)));
            else if (pick == 7)
                run_lifecycle(NOISE_BASE + 10'($urandom_range(0, 15)));
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    if ($urandom_range(0, 3) == 0)
                        noise_idx = 10'($urandom_range(512, 1022));
                    else
                        noise_idx = NOISE_BASE + 10'($urandom_range(0, 15));
                    send(4'($urandom_range(0, 15)), noise_idx);
                end
            end
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        // Drain, then watch for any stray word before the verdict
        while (outstanding != 0) @(negedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_region_lifecycle_table: done, clean");
        else
            $display("tb_region_lifecycle_table: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rlt_pkg.sv
hw/rtl/rlt_ram.sv
hw/rtl/rlt_rules.sv
hw/rtl/region_lifecycle_table.sv
tb/rlt_lifecycle_checker.sv
tb/tb_region_lifecycle_table.sv
